// ===== sv/pcm_voice_mixer_defines.svh =====
// Assertion macros shared by the mixer checker.
// Depends on nothing; take it in with a plain include.
`ifndef PCM_VOICE_MIXER_DEFINES_SVH
`define PCM_VOICE_MIXER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define PVM_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pvm check failed");

// next-cycle implication, quiet during reset
`define PVM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pvm check failed");

`endif

// ===== sv/pvm_pkg.sv =====
// Types and codes of the PCM voice mixer: beat structs and item kinds.
// Depends on nothing; used by the mixer and its checker.
package pvm_pkg;

   localparam logic [2:0] KIND_TICK  = 3'd0;
   localparam logic [2:0] KIND_START = 3'd1;
   localparam logic [2:0] KIND_STOP  = 3'd2;
   localparam logic [2:0] KIND_BYTE  = 3'd3;
   localparam logic [2:0] KIND_ENTRY = 3'd4;

   // accumulator width of the mix, covers up to 32 voices
   localparam int MIX_W = 24;
   localparam logic [3:0] VOLUME_RESET = 4'd8;

   typedef struct packed {
      logic [2:0]         kind;
      logic [6:0]         sound_id;
      logic [2:0]         voice;
      logic [15:0]        address;
      logic [7:0]         sample_byte;
      logic [15:0]        sound_length;
      logic [15:0]        sound_rate;
      logic               exclusive;
      logic               present;
      logic signed [15:0] music_sample;
      logic               music_on;
      logic [31:0]        game_tic;
   } pvm_req_type;

   typedef struct packed {
      logic signed [15:0] mix_sample;
      logic [2:0]         started_voice;
      logic               start_ok;
      logic               any_playing;
   } pvm_rsp_type;

endpackage

// ===== sv/pcm_voice_mixer.sv =====
// PCM voice mixer top level: sample memory, sound table memory, voice file,
// shared restoring divider and the sequencer. Depends on pvm_pkg.
//
// channel | direction | handshake             | beat
// req     | in        | req_valid/req_ready   | pvm_req_type
// rsp     | out       | rsp_valid/rsp_ready   | pvm_rsp_type
// csr     | in/out    | APB, pready tied high | sfx_volume at byte 0
//
// One item at a time; req_ready is high only in idle. A tick walks the voices:
// for each playing voice it reads the table entry, advances the phase, wraps
// the address into the sample store and reads the sample; idle voices are
// skipped. It then runs up to two divider passes. A start scans the voices
// for a slot. A stop, an unused kind or a tick with no effect goes straight
// to the result. Synchronous active-high reset clears voices, present bits and
// control. A result held by rsp_ready keeps the sequencer waiting.
module pcm_voice_mixer
   import pvm_pkg::*;
#(
   parameter int VOICES       = 8,
   parameter int SOUNDS       = 128,
   parameter int SAMPLE_DEPTH = 65536,
   parameter int OUTPUT_RATE  = 22050
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  pvm_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output pvm_rsp_type rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ADDR_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
   localparam int MA_W   = (ADDR_W > 16) ? ADDR_W + 1 : 17;
   localparam int SND_AW = (SOUNDS > 1) ? $clog2(SOUNDS) : 1;
   localparam int ID_XW  = (SND_AW > 7) ? SND_AW : 7;
   localparam int V_AW   = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int VF_W   = (V_AW > 3) ? V_AW : 3;
   localparam int SRC_W  = $clog2(VOICES + 1);
   localparam int STEP_W = $clog2((64'hFFFF0000 / OUTPUT_RATE) + 1);
   localparam int ENT_W  = 32 + STEP_W + 1;
   localparam int DVS_W  = (SRC_W > 4) ? SRC_W : 4;
   // step = floor(rate * 2^16 / OUTPUT_RATE) by reciprocal multiplication
   localparam int RCP_SH = 16 + $clog2(OUTPUT_RATE);
   localparam logic [32:0] RCP_M = 33'(((64'd1 << (RCP_SH + 16)) + 64'(OUTPUT_RATE) - 64'd1)
                                       / 64'(OUTPUT_RATE));
   localparam int PROD_W = ((RCP_SH + STEP_W) > 49) ? RCP_SH + STEP_W : 49;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_EXEC  = 5'd1;
   localparam logic [4:0] S_TENT  = 5'd2;
   localparam logic [4:0] S_TPOS  = 5'd3;
   localparam logic [4:0] S_TMOD  = 5'd4;
   localparam logic [4:0] S_TSMP  = 5'd5;
   localparam logic [4:0] S_MIX1  = 5'd6;
   localparam logic [4:0] S_MIXW1 = 5'd7;
   localparam logic [4:0] S_MIXW2 = 5'd8;
   localparam logic [4:0] S_SEXC  = 5'd9;
   localparam logic [4:0] S_SSCAN = 5'd10;
   localparam logic [4:0] S_SSET  = 5'd11;
   localparam logic [4:0] S_WMOD  = 5'd12;
   localparam logic [4:0] S_EDIV  = 5'd13;
   localparam logic [4:0] S_DONE  = 5'd14;

   // storage
   logic [7:0]       smem [SAMPLE_DEPTH];
   logic [7:0]       smem_q;
   logic [ENT_W-1:0] tbl [SOUNDS];
   logic [ENT_W-1:0] tbl_q;

   // control and voice registers
   logic [4:0]              state_ff, state_in;
   pvm_req_type             req_ff, req_in;
   logic [3:0]              vol_ff, vol_in;
   logic [SOUNDS-1:0]       present_ff, present_in;
   logic [VOICES-1:0]       active_ff, active_in;
   logic [SND_AW-1:0]       vsound_ff [VOICES];
   logic [SND_AW-1:0]       vsound_in [VOICES];
   logic [31:0]             phase_ff [VOICES];
   logic [31:0]             phase_in [VOICES];
   logic [31:0]             vtick_ff [VOICES];
   logic [31:0]             vtick_in [VOICES];
   logic [V_AW-1:0]         vi_ff, vi_in;
   logic [V_AW-1:0]         slot_ff, slot_in;
   logic [31:0]             oldest_ff, oldest_in;
   logic [MA_W-1:0]         maddr_ff, maddr_in;
   logic signed [MIX_W-1:0] tot_ff, tot_in;
   logic [SRC_W-1:0]        src_ff, src_in;
   logic                    neg_ff, neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   pvm_rsp_type             rsp_ff, rsp_in;
   logic signed [15:0]      res_mix_ff, res_mix_in;
   logic                    res_ok_ff, res_ok_in;

   // divider registers
   logic             div_run_ff;
   logic [4:0]       div_cnt_ff;
   logic [31:0]      div_q_ff;
   logic [DVS_W:0]   div_r_ff;
   logic [DVS_W-1:0] div_d_ff;
   logic             div_go;
   logic [31:0]      div_a;
   logic [DVS_W-1:0] div_b;
   logic [DVS_W:0]   div_r2;

   // memory strobes
   logic              smem_we, smem_re;
   logic              tbl_we, tbl_re;
   logic [SND_AW-1:0] tbl_wa, tbl_ra;
   logic [ENT_W-1:0]  tbl_wd;

   // decoded item and entry fields
   logic [ID_XW-1:0]   id_x;
   logic [SND_AW-1:0]  id_a;
   logic               id_ok;
   logic [VF_W-1:0]    voice_x;
   logic [VF_W-1:0]    slot_x;
   logic [15:0]        ent_base, ent_len;
   logic [STEP_W-1:0]  ent_step;
   logic               ent_excl;
   logic [15:0]        pos;
   logic [32:0]        phase_sum;
   logic [PROD_W-1:0]  step_prod;
   logic signed [MIX_W-1:0] tot7, qs, t2, music_x;
   logic [SRC_W-1:0]   src2;
   logic               last_voice;
   logic               csr_wr;

   function automatic logic signed [15:0] sat16(input logic signed [MIX_W-1:0] v);
      logic signed [15:0] r;
      if (v > MIX_W'(32767))
         r = 16'sh7FFF;
      else if (v < -MIX_W'(32768))
         r = -16'sh8000;
      else
         r = v[15:0];
      return r;
   endfunction

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = {28'd0, vol_ff};
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & ~csr_paddr[2];

   assign id_x       = ID_XW'(req_ff.sound_id);
   assign id_a       = id_x[SND_AW-1:0];
   assign id_ok      = (32'(id_x) < 32'(SOUNDS));
   assign voice_x    = VF_W'(req_ff.voice);
   assign slot_x     = VF_W'(slot_ff);
   assign last_voice = (32'(vi_ff) == 32'(VOICES - 1));

   assign ent_base   = tbl_q[ENT_W-1 -: 16];
   assign ent_len    = tbl_q[ENT_W-17 -: 16];
   assign ent_step   = tbl_q[STEP_W:1];
   assign ent_excl   = tbl_q[0];

   assign pos        = phase_ff[vi_ff][31:16];
   assign phase_sum  = {1'b0, phase_ff[vi_ff]} + 33'(ent_step);
   assign step_prod  = PROD_W'(req_ff.sound_rate) * PROD_W'(RCP_M);
   assign tot7       = tot_ff <<< 7;
   assign qs         = neg_ff ? -$signed(div_q_ff[MIX_W-1:0]) : $signed(div_q_ff[MIX_W-1:0]);
   assign music_x    = req_ff.music_on ? MIX_W'(req_ff.music_sample) : '0;
   assign t2         = qs + music_x;
   assign src2       = (req_ff.music_on && src_ff == '0) ? SRC_W'(1) : src_ff;

   // one quotient bit per cycle
   assign div_r2 = {div_r_ff[DVS_W-1:0], div_q_ff[31]};

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      vol_in       = csr_wr ? csr_pwdata[3:0] : vol_ff;
      present_in   = present_ff;
      active_in    = active_ff;
      vsound_in    = vsound_ff;
      phase_in     = phase_ff;
      vtick_in     = vtick_ff;
      vi_in        = vi_ff;
      slot_in      = slot_ff;
      oldest_in    = oldest_ff;
      maddr_in     = maddr_ff;
      tot_in       = tot_ff;
      src_in       = src_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      res_mix_in   = res_mix_ff;
      res_ok_in    = res_ok_ff;
      div_go       = 1'b0;
      div_a        = '0;
      div_b        = '0;
      smem_we      = 1'b0;
      smem_re      = 1'b0;
      tbl_we       = 1'b0;
      tbl_re       = 1'b0;
      tbl_wa       = id_a;
      tbl_ra       = id_a;
      tbl_wd       = '0;

      // retire the output beat
      if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_mix_in = '0;
            res_ok_in  = 1'b0;
            slot_in    = '0;
            state_in   = S_DONE;
            case (req_ff.kind)
               KIND_TICK: begin
                  if (vol_ff == 4'd0 || active_ff == '0) begin
                     res_mix_in = req_ff.music_on ? req_ff.music_sample : 16'sd0;
                  end else begin
                     vi_in    = '0;
                     tot_in   = '0;
                     src_in   = '0;
                     state_in = S_TENT;
                  end
               end
               KIND_START: begin
                  if (id_ok && present_ff[id_a]) begin
                     tbl_re   = 1'b1;
                     state_in = S_SEXC;
                  end
               end
               KIND_STOP: begin
                  if (32'(voice_x) < 32'(VOICES))
                     active_in[voice_x[V_AW-1:0]] = 1'b0;
               end
               KIND_BYTE: begin
                  maddr_in = MA_W'(req_ff.address);
                  state_in = S_WMOD;
               end
               KIND_ENTRY: begin
                  if (id_ok)
                     state_in = S_EDIV;
               end
               default: begin
               end
            endcase
         end
         // tick: fetch the voice's table entry
         S_TENT: begin
            if (active_ff[vi_ff]) begin
               tbl_ra   = vsound_ff[vi_ff];
               tbl_re   = 1'b1;
               state_in = S_TPOS;
            end else if (last_voice) begin
               state_in = S_MIX1;
            end else begin
               vi_in = vi_ff + 1'b1;
            end
         end
         // advance phase, end the voice past its length
         S_TPOS: begin
            phase_in[vi_ff] = phase_sum[32] ? 32'hFFFF_FFFF : phase_sum[31:0];
            if (pos >= ent_len) begin
               active_in[vi_ff] = 1'b0;
               if (last_voice)
                  state_in = S_MIX1;
               else begin
                  vi_in    = vi_ff + 1'b1;
                  state_in = S_TENT;
               end
            end else begin
               maddr_in = MA_W'(ent_base) + MA_W'(pos);
               state_in = S_TMOD;
            end
         end
         // wrap the address into the sample store, then read
         S_TMOD: begin
            if (32'(maddr_ff) >= 32'(SAMPLE_DEPTH)) begin
               maddr_in = maddr_ff - MA_W'(SAMPLE_DEPTH);
            end else begin
               smem_re  = 1'b1;
               state_in = S_TSMP;
            end
         end
         S_TSMP: begin
            if (smem_q != 8'd0) begin
               tot_in = tot_ff + MIX_W'(smem_q) - MIX_W'(127);
               src_in = src_ff + 1'b1;
            end
            if (last_voice)
               state_in = S_MIX1;
            else begin
               vi_in    = vi_ff + 1'b1;
               state_in = S_TENT;
            end
         end
         // scale by 128/(16-volume)
         S_MIX1: begin
            neg_in   = tot7 < 0;
            div_go   = 1'b1;
            div_a    = 32'(tot7 < 0 ? -tot7 : tot7);
            div_b    = DVS_W'(5'd16 - {1'b0, vol_ff});
            state_in = S_MIXW1;
         end
         // add music, average over sources
         S_MIXW1: begin
            if (!div_run_ff) begin
               if (src2 != '0) begin
                  neg_in   = t2 < 0;
                  div_go   = 1'b1;
                  div_a    = 32'(t2 < 0 ? -t2 : t2);
                  div_b    = DVS_W'(src2);
                  state_in = S_MIXW2;
               end else begin
                  res_mix_in = sat16(t2);
                  state_in   = S_DONE;
               end
            end
         end
         S_MIXW2: begin
            if (!div_run_ff) begin
               res_mix_in = sat16(qs);
               state_in   = S_DONE;
            end
         end
         // start: drop other instances of an exclusive sound
         S_SEXC: begin
            for (int i = 0; i < VOICES; i++)
               if (ent_excl && active_ff[i] && vsound_ff[i] == id_a)
                  active_in[i] = 1'b0;
            vi_in     = '0;
            slot_in   = '0;
            oldest_in = req_ff.game_tic;
            state_in  = S_SSCAN;
         end
         // first free voice, else oldest start tick
         S_SSCAN: begin
            if (!active_ff[vi_ff]) begin
               slot_in  = vi_ff;
               state_in = S_SSET;
            end else begin
               if (vtick_ff[vi_ff] < oldest_ff) begin
                  slot_in   = vi_ff;
                  oldest_in = vtick_ff[vi_ff];
               end
               if (last_voice)
                  state_in = S_SSET;
               else
                  vi_in = vi_ff + 1'b1;
            end
         end
         S_SSET: begin
            active_in[slot_ff] = 1'b1;
            vsound_in[slot_ff] = id_a;
            phase_in[slot_ff]  = '0;
            vtick_in[slot_ff]  = req_ff.game_tic;
            res_ok_in          = 1'b1;
            state_in           = S_DONE;
         end
         S_WMOD: begin
            if (32'(maddr_ff) >= 32'(SAMPLE_DEPTH))
               maddr_in = maddr_ff - MA_W'(SAMPLE_DEPTH);
            else begin
               smem_we  = 1'b1;
               state_in = S_DONE;
            end
         end
         // write the entry with its phase step
         S_EDIV: begin
            tbl_we           = 1'b1;
            tbl_wd           = {req_ff.address, req_ff.sound_length,
                                step_prod[RCP_SH +: STEP_W], req_ff.exclusive};
            present_in[id_a] = req_ff.present;
            state_in         = S_DONE;
         end
         // hand the result to the output register
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.mix_sample     = res_mix_ff;
               rsp_in.started_voice  = res_ok_ff ? slot_x[2:0] : 3'd0;
               rsp_in.start_ok       = res_ok_ff;
               rsp_in.any_playing    = |active_ff;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and voice registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vol_ff       <= VOLUME_RESET;
         present_ff   <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < VOICES; i++) begin
            vsound_ff[i] <= '0;
            phase_ff[i]  <= '0;
            vtick_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         vol_ff       <= vol_in;
         present_ff   <= present_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         vsound_ff    <= vsound_in;
         phase_ff     <= phase_in;
         vtick_ff     <= vtick_in;
      end
      req_ff     <= req_in;
      vi_ff      <= vi_in;
      slot_ff    <= slot_in;
      oldest_ff  <= oldest_in;
      maddr_ff   <= maddr_in;
      tot_ff     <= tot_in;
      src_ff     <= src_in;
      neg_ff     <= neg_in;
      rsp_ff     <= rsp_in;
      res_mix_ff <= res_mix_in;
      res_ok_ff  <= res_ok_in;
   end

   // shared restoring divider
   always_ff @(posedge clock) begin
      if (reset) begin
         div_run_ff <= 1'b0;
         div_cnt_ff <= '0;
      end else if (div_go) begin
         div_run_ff <= 1'b1;
         div_cnt_ff <= '0;
      end else if (div_run_ff) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
         if (div_cnt_ff == 5'd31)
            div_run_ff <= 1'b0;
      end
      if (div_go) begin
         div_q_ff <= div_a;
         div_r_ff <= '0;
         div_d_ff <= div_b;
      end else if (div_run_ff) begin
         if (div_r2 >= {1'b0, div_d_ff}) begin
            div_r_ff <= div_r2 - {1'b0, div_d_ff};
            div_q_ff <= {div_q_ff[30:0], 1'b1};
         end else begin
            div_r_ff <= div_r2;
            div_q_ff <= {div_q_ff[30:0], 1'b0};
         end
      end
   end

   // sample store
   always_ff @(posedge clock) begin
      if (smem_we)
         smem[maddr_ff[ADDR_W-1:0]] <= req_ff.sample_byte;
      if (smem_re)
         smem_q <= smem[maddr_ff[ADDR_W-1:0]];
   end

   // sound table
   always_ff @(posedge clock) begin
      if (tbl_we)
         tbl[tbl_wa] <= tbl_wd;
      if (tbl_re)
         tbl_q <= tbl[tbl_ra];
   end

endmodule

// ===== sv/pvm_checker.sv =====
// Port-level checker for the PCM voice mixer, bound to the top level.
// Depends on pvm_pkg and pcm_voice_mixer_defines.svh.
`include "pcm_voice_mixer_defines.svh"

module pvm_checker
   import pvm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input pvm_rsp_type rsp_data,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [2:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata
);

   // a stalled result beat holds
   `PVM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   // a granted voice is playing afterwards
   `PVM_ASSERT_NOW(a_start_plays, rsp_valid && rsp_data.start_ok, rsp_data.any_playing)
   // a start beat carries no mix
   `PVM_ASSERT_NOW(a_start_silent, rsp_valid && rsp_data.start_ok, rsp_data.mix_sample == 16'sd0)
   // volume write reads back next cycle
   `PVM_ASSERT_NEXT(a_vol_write, csr_psel && csr_penable && csr_pwrite && !csr_paddr[2],
                    csr_prdata[3:0] == $past(csr_pwdata[3:0]))

endmodule

bind pcm_voice_mixer pvm_checker u_pvm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_data    (rsp_data),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);

// ===== dv/pcm_voice_mixer_tb.sv =====
// Self-checking bench for the eight-voice PCM mixer: drives load, start, stop
// and tick beats, predicts each result beat and compares field by field.
// Depends on pvm_pkg and the pcm_voice_mixer RTL.
module pcm_voice_mixer_tb;
   import pvm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_VOICES = 8;
   localparam int NUM_SOUNDS = 128;
   localparam int LIMIT_CYCLES = 900000;
   localparam logic [2:0] ADDR_VOLUME = 3'd0;
   localparam logic [2:0] KIND_UNUSED = 3'd5;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   pvm_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   pvm_rsp_type rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pcm_voice_mixer i_dut (.*);

   always #10 clock = ~clock;

   // mixer image
   logic [7:0]  mem_bytes [0:65535];
   logic [15:0] snd_base [NUM_SOUNDS];
   logic [15:0] snd_len [NUM_SOUNDS];
   logic [31:0] snd_step [NUM_SOUNDS];
   logic        snd_excl [NUM_SOUNDS];
   logic        snd_pres [NUM_SOUNDS];
   logic        vc_on [NUM_VOICES];
   logic [6:0]  vc_snd [NUM_VOICES];
   logic [31:0] vc_phase [NUM_VOICES];
   logic [31:0] vc_tic [NUM_VOICES];
   logic [3:0]  volume;

   pvm_req_type pending_beats[$];
   pvm_rsp_type expected_rsp[$];
   int  mismatches = 0;
   int  rsp_count = 0;
   int  ticks_sent = 0;
   int  starts_ok = 0;
   longint cycles = 0;
   bit  idle_off = 1'b0;
   int  req_gap = 0;
   int  rsp_gap = 0;

   function automatic bit any_voice_on();
      for (int i = 0; i < NUM_VOICES; i++) if (vc_on[i]) return 1'b1;
      return 1'b0;
   endfunction

   // advance the image by one beat and return the result it causes
   function automatic pvm_rsp_type mix_predict(pvm_req_type b);
      pvm_rsp_type r;
      int total, srcs, slot, mus;
      logic [31:0] oldest, pos, sum;
      logic [7:0] smp;
      r = '0;
      mus = int'(b.music_sample);
      case (b.kind)
         KIND_TICK: begin
            if (volume == 0 || !any_voice_on()) begin
               total = b.music_on ? mus : 0;
            end else begin
               total = 0;
               srcs = 0;
               for (int i = 0; i < NUM_VOICES; i++) begin
                  if (!vc_on[i]) continue;
                  pos = vc_phase[i] >> 16;
                  sum = vc_phase[i] + snd_step[vc_snd[i]];
                  vc_phase[i] = (sum < vc_phase[i]) ? 32'hFFFF_FFFF : sum;
                  if (pos >= snd_len[vc_snd[i]]) begin
                     vc_on[i] = 1'b0;
                     continue;
                  end
                  smp = mem_bytes[16'(snd_base[vc_snd[i]] + pos)];
                  if (smp != 0) begin
                     total += int'(smp) - 127;
                     srcs++;
                  end
               end
               total = total * 128;
               total = total / (16 - int'(volume));
               if (b.music_on) begin
                  total += mus;
                  if (srcs == 0) srcs = 1;
               end
               if (srcs > 0) total = total / srcs;
               if (total > 32767) total = 32767;
               else if (total < -32768) total = -32768;
            end
            r.mix_sample = 16'(total);
         end
         KIND_START: begin
            if (snd_pres[b.sound_id]) begin
               oldest = b.game_tic;
               slot = 0;
               if (snd_excl[b.sound_id])
                  for (int i = 0; i < NUM_VOICES; i++)
                     if (vc_on[i] && vc_snd[i] == b.sound_id) vc_on[i] = 1'b0;
               for (int i = 0; i < NUM_VOICES; i++) begin
                  if (!vc_on[i]) begin
                     slot = i;
                     break;
                  end else if (vc_tic[i] < oldest) begin
                     slot = i;
                     oldest = vc_tic[i];
                  end
               end
               vc_on[slot] = 1'b1;
               vc_snd[slot] = b.sound_id;
               vc_phase[slot] = '0;
               vc_tic[slot] = b.game_tic;
               r.started_voice = 3'(slot);
               r.start_ok = 1'b1;
            end
         end
         KIND_STOP: vc_on[b.voice] = 1'b0;
         KIND_BYTE: mem_bytes[b.address] = b.sample_byte;
         KIND_ENTRY: begin
            snd_base[b.sound_id] = b.address;
            snd_len[b.sound_id] = b.sound_length;
            snd_step[b.sound_id] = 32'((64'(b.sound_rate) << 16) / 64'd22050);
            snd_excl[b.sound_id] = b.exclusive;
            snd_pres[b.sound_id] = b.present;
         end
         default: ;
      endcase
      r.any_playing = any_voice_on();
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on beat %0d: %s got %0d want %0d", rsp_count, what, got, want);
      mismatches++;
   endtask

   // drive request beats from the pending queue
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_rsp.push_back(mix_predict(req_data));
            if (req_data.kind == KIND_TICK) ticks_sent++;
         end
         if (!(req_valid && !req_ready)) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_beats.size() > 0 && !idle_off && $urandom_range(0, 9) == 0) begin
               req_gap <= $urandom_range(0, 4);
               req_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               req_data <= pending_beats.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // check result beats against the oldest expectation
   always @(posedge clock) begin
      pvm_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected beat", 0, 0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.mix_sample !== want.mix_sample)
                  report_mismatch("mix_sample", int'(rsp_data.mix_sample),
                                  int'(want.mix_sample));
               if (rsp_data.started_voice !== want.started_voice)
                  report_mismatch("started_voice", int'(rsp_data.started_voice),
                                  int'(want.started_voice));
               if (rsp_data.start_ok !== want.start_ok)
                  report_mismatch("start_ok", int'(rsp_data.start_ok), int'(want.start_ok));
               if (rsp_data.any_playing !== want.any_playing)
                  report_mismatch("any_playing", int'(rsp_data.any_playing),
                                  int'(want.any_playing));
               if (want.start_ok) starts_ok++;
            end
            rsp_count++;
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!idle_off && $urandom_range(0, 7) == 0) begin
            rsp_gap <= $urandom_range(0, 4);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("pcm_voice_mixer regression: fail");
         $finish;
      end
   end

   task automatic csr_write(logic [3:0] v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_VOLUME;
      csr_pwdata <= 32'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      volume = v;
   endtask

   task automatic drain();
      while (pending_beats.size() > 0 || req_valid || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic pvm_req_type blank_beat(logic [2:0] k);
      pvm_req_type b;
      b = '0;
      b.kind = k;
      return b;
   endfunction

   task automatic push_byte(logic [15:0] a, logic [7:0] v);
      pvm_req_type b;
      b = blank_beat(KIND_BYTE);
      b.address = a;
      b.sample_byte = v;
      pending_beats.push_back(b);
   endtask

   // push one sound table entry beat
   task automatic push_entry(logic [6:0] id, logic [15:0] base, logic [15:0] len,
                             logic [15:0] rate, logic ex, logic pr);
      pvm_req_type b;
      b = blank_beat(KIND_ENTRY);
      b.sound_id = id;
      b.address = base;
      b.sound_length = len;
      b.sound_rate = rate;
      b.exclusive = ex;
      b.present = pr;
      pending_beats.push_back(b);
   endtask

   task automatic push_start(logic [6:0] id, logic [31:0] tic);
      pvm_req_type b;
      b = blank_beat(KIND_START);
      b.sound_id = id;
      b.game_tic = tic;
      b.address = 16'($urandom);
      pending_beats.push_back(b);
   endtask

   task automatic push_tick(logic [15:0] m, logic on);
      pvm_req_type b;
      b = blank_beat(KIND_TICK);
      b.music_sample = m;
      b.music_on = on;
      b.game_tic = $urandom;
      pending_beats.push_back(b);
   endtask

   task automatic push_random(int n, logic [31:0] tic_base);
      pvm_req_type b;
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 55) push_tick(16'($urandom), 1'($urandom_range(0, 1)));
         else if (sel < 72) push_start(7'($urandom_range(0, 15)),
                                       tic_base + $urandom_range(0, 60));
         else if (sel < 78) push_start(7'($urandom_range(16, 127)), $urandom);
         else if (sel < 84) begin
            b = blank_beat(KIND_STOP);
            b.voice = 3'($urandom_range(0, 7));
            pending_beats.push_back(b);
         end else if (sel < 90) begin
            // table points into the written window 0..255, short lengths
            push_entry(7'($urandom_range(0, 15)), 16'($urandom_range(0, 127)),
                       16'($urandom_range(0, 128)), 16'($urandom),
                       1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0);
         end else if (sel < 96) begin
            push_byte(16'($urandom_range(0, 255)), 8'($urandom));
         end else begin
            b = blank_beat(3'($urandom_range(KIND_UNUSED, 7)));
            b.sound_id = 7'($urandom);
            b.voice = 3'($urandom);
            b.game_tic = $urandom;
            b.address = 16'($urandom);
            pending_beats.push_back(b);
         end
      end
   endtask

   initial begin
      logic [3:0] vols [5];
      for (int i = 0; i < 65536; i++) begin
         mem_bytes[i] = '0;
      end
      for (int i = 0; i < NUM_SOUNDS; i++) begin
         snd_base[i] = '0; snd_len[i] = '0; snd_step[i] = '0;
         snd_excl[i] = 1'b0; snd_pres[i] = 1'b0;
      end
      for (int i = 0; i < NUM_VOICES; i++) begin
         vc_on[i] = 1'b0; vc_snd[i] = '0; vc_phase[i] = '0; vc_tic[i] = '0;
      end
      volume = VOLUME_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every kind, absent, exclusive, end of sound
      push_byte(16'd0, 8'd255);
      push_byte(16'd1, 8'd0);
      push_byte(16'hFFFF, 8'd1);
      push_byte(16'd2, 8'd127);
      push_entry(7'd0, 16'hFFFF, 16'd3, 16'd65535, 1'b1, 1'b1);
      push_entry(7'd127, 16'd0, 16'hFFFF, 16'd22050, 1'b0, 1'b1);
      push_entry(7'd1, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1);
      push_tick(16'h8000, 1'b1);
      push_start(7'd5, 32'hFFFF_FFFF);
      push_start(7'd0, 32'd10);
      push_start(7'd0, 32'd11);
      push_tick(16'h7FFF, 1'b1);
      push_tick(16'h0000, 1'b0);
      push_start(7'd1, 32'd3);
      push_tick(16'h8000, 1'b1);
      begin
         pvm_req_type b;
         b = blank_beat(KIND_STOP);
         b.voice = 3'd7;
         pending_beats.push_back(b);
         b = '1;
         b.kind = 3'd7;
         pending_beats.push_back(b);
      end
      for (int i = 0; i < 4; i++) push_tick(16'($urandom), 1'b1);
      drain();

      // fill a window so table entries only read written bytes
      for (int a = 0; a < 256; a++) push_byte(16'(a), 8'($urandom));
      drain();
      // stop everything left over from the directed part that may hit unwritten bytes
      for (int v = 0; v < NUM_VOICES; v++) begin
         pvm_req_type b;
         b = blank_beat(KIND_STOP);
         b.voice = 3'(v);
         pending_beats.push_back(b);
      end
      for (int s = 0; s < 16; s++)
         push_entry(7'(s), 16'($urandom_range(0, 127)), 16'($urandom_range(1, 128)),
                    16'($urandom), 1'($urandom_range(0, 1)), 1'b1);
      push_entry(7'd127, 16'd0, 16'd200, 16'd65535, 1'b0, 1'b1);
      drain();

      vols[0] = 4'd15; vols[1] = 4'd0; vols[2] = 4'd1; vols[3] = 4'd8; vols[4] = 4'd15;
      for (int p = 0; p < 5; p++) begin
         csr_write(p == 4 ? 4'($urandom_range(1, 14)) : vols[p]);
         if (p == 4) idle_off = 1'b1;
         push_random(170, 32'(p * 40) + (p == 3 ? 32'hFFFF_FF00 : 32'd0));
         drain();
      end

      $display("covered %0d result beats: %0d ticks, %0d granted starts", rsp_count,
               ticks_sent, starts_ok);
      $display("volume swept over 0, 1, 8, 15 and a random setting");
      if (mismatches == 0) begin
         $display("pcm_voice_mixer regression: pass");
      end else begin
         $display("pcm_voice_mixer regression: fail");
      end
      $finish;
   end

endmodule
